[src/owag_pkg.sv]
// ----------------------------------------------------------------------------
// owag_pkg
// Shared types, register codes and constant-divisor helpers for the
// on-screen widget alpha generator.
// ----------------------------------------------------------------------------
package owag_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int GW        = 15;
  localparam int SETTLE_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POS    = 2'd3;

  localparam logic [2:0] KIND_HSLIDER = 3'd0;
  localparam logic [2:0] KIND_VSLIDER = 3'd1;
  localparam logic [2:0] KIND_PAUSE   = 3'd2;
  localparam logic [2:0] KIND_PLAY    = 3'd3;
  localparam logic [2:0] KIND_SPEAKER = 3'd4;
  localparam logic [2:0] KIND_MUTE    = 3'd5;

  localparam logic [2:0]        RST_KIND   = KIND_HSLIDER;
  localparam logic [CFG_W-1:0]  RST_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0]  RST_HEIGHT = 12'd480;
  localparam logic [6:0]        RST_POS    = 7'd0;
  localparam logic [6:0]        POS_MAX    = 7'd100;

  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd4;

  localparam logic [7:0] ALPHA_ON  = 8'hFF;
  localparam logic [7:0] ALPHA_OFF = 8'h00;

  localparam int RECIP_SHIFT  = 24;
  localparam int DIV100_SHIFT = 26;
  localparam logic [23:0] RECIP_3  = 24'((2**24 + 2) / 3);
  localparam logic [23:0] RECIP_10 = 24'((2**24 + 9) / 10);
  localparam logic [23:0] RECIP_15 = 24'((2**24 + 14) / 15);
  localparam logic [23:0] RECIP_20 = 24'((2**24 + 19) / 20);
  localparam logic [23:0] RECIP_40 = 24'((2**24 + 39) / 40);
  localparam logic [19:0] RECIP_100 = 20'((2**26 + 99) / 100);

  typedef struct packed {
    logic [2:0]             kind;
    logic                   empty;
    logic                   fwd;
    logic signed [GW-1:0]   rx;
    logic signed [GW-1:0]   ry;
    logic signed [GW-1:0]   w;
    logic signed [GW-1:0]   h;
    logic signed [GW-1:0]   wm1;
    logic signed [GW-1:0]   hm1;
    logic signed [GW-1:0]   wm2;
    logic signed [GW-1:0]   wm3;
    logic signed [GW-1:0]   hm3;
    logic signed [GW-1:0]   xlo;
    logic signed [GW-1:0]   xhi;
    logic signed [GW-1:0]   vy1;
    logic signed [GW-1:0]   mid;
    logic signed [GW-1:0]   bar;
    logic signed [GW-1:0]   wmb;
    logic signed [GW-1:0]   delta;
    logic signed [GW-1:0]   wmd;
    logic signed [GW-1:0]   y2;
    logic signed [GW-1:0]   q;
    logic signed [GW-1:0]   hm1q;
  } geom_t;

  function automatic logic [CFG_W-1:0] div12(input logic [CFG_W-1:0] x,
                                             input logic [23:0] recip);
    logic [35:0] p;
    p = 36'(x) * 36'(recip);
    return p[RECIP_SHIFT +: CFG_W];
  endfunction

  function automatic logic [12:0] div100(input logic [19:0] x);
    logic [39:0] p;
    p = 40'(x) * 40'(RECIP_100);
    return p[DIV100_SHIFT +: 13];
  endfunction

  function automatic logic signed [GW-1:0] to_s(input logic [CFG_W-1:0] x);
    return $signed({{(GW-CFG_W){1'b0}}, x});
  endfunction

endpackage

[src/owag_if.sv]
// ----------------------------------------------------------------------------
// owag_if
// Valid/ready channels for pixel coordinates in and alpha results out.
// ----------------------------------------------------------------------------
interface owag_pix_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] screen_x;
  logic [COORD_BITS-1:0] screen_y;

  modport source (output valid, screen_x, screen_y, input ready);
  modport sink   (input valid, screen_x, screen_y, output ready);
endinterface

interface owag_alpha_if ();
  logic       valid;
  logic       ready;
  logic [7:0] alpha;
  logic       in_region;

  modport source (output valid, alpha, in_region, input ready);
  modport sink   (input valid, alpha, in_region, output ready);
endinterface

[src/owag_geometry.sv]
// ----------------------------------------------------------------------------
// owag_geometry
// Configuration registers and a four-stage setup pipeline that turns the
// render size, widget kind and slider level into region and shape bounds.
// ----------------------------------------------------------------------------
module owag_geometry (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [owag_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [owag_pkg::CFG_W-1:0]          cfg_wdata_i,
  output owag_pkg::geom_t                     geom_o,
  output logic                                settled_o
);

  localparam int GW = owag_pkg::GW;

  logic [2:0]                     kind_q;
  logic [owag_pkg::CFG_W-1:0]     rw_q, rh_q;
  logic [6:0]                     pos_q;
  logic [owag_pkg::SETTLE_W-1:0]  settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= owag_pkg::RST_KIND;
      rw_q     <= owag_pkg::RST_WIDTH;
      rh_q     <= owag_pkg::RST_HEIGHT;
      pos_q    <= owag_pkg::RST_POS;
      settle_q <= owag_pkg::SETTLE_CYCLES;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          owag_pkg::CFG_KIND:   kind_q <= cfg_wdata_i[2:0];
          owag_pkg::CFG_WIDTH:  rw_q   <= cfg_wdata_i;
          owag_pkg::CFG_HEIGHT: rh_q   <= cfg_wdata_i;
          owag_pkg::CFG_POS:    pos_q  <= cfg_wdata_i[6:0];
        endcase
        settle_q <= owag_pkg::SETTLE_CYCLES;
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 1'b1;
      end
    end
  end

  assign settled_o = (settle_q == '0);

  // stage A: constant-divisor margins
  logic [2:0]                 a_kind_q;
  logic [6:0]                 a_pos_q;
  logic [owag_pkg::CFG_W-1:0] a_rw_q, a_rh_q, a_m10_q, a_m20_q, a_m15_q;
  logic [owag_pkg::CFG_W-1:0] a_w20_q, a_w40_q;

  always_ff @(posedge clk_i) begin
    a_kind_q <= kind_q;
    a_pos_q  <= (pos_q > owag_pkg::POS_MAX) ? owag_pkg::POS_MAX : pos_q;
    a_rw_q   <= rw_q;
    a_rh_q   <= rh_q;
    a_m10_q  <= owag_pkg::div12(rh_q, owag_pkg::RECIP_10);
    a_m20_q  <= owag_pkg::div12(rh_q, owag_pkg::RECIP_20);
    a_m15_q  <= owag_pkg::div12(rh_q, owag_pkg::RECIP_15);
    a_w20_q  <= owag_pkg::div12(rw_q, owag_pkg::RECIP_20);
    a_w40_q  <= owag_pkg::div12(rw_q, owag_pkg::RECIP_40);
  end

  // stage B: region placement
  logic [2:0]           b_kind_q;
  logic [6:0]           b_pos_q;
  logic signed [GW-1:0] b_w_q, b_h_q, b_rx_q, b_ry_q;
  logic signed [GW-1:0] b_w_d, b_h_d, b_rx_d, b_ry_d;

  always_comb begin
    if (a_kind_q == owag_pkg::KIND_HSLIDER) begin
      b_w_d  = owag_pkg::to_s(a_rw_q) - (owag_pkg::to_s(a_m10_q) <<< 1);
      b_h_d  = owag_pkg::to_s(a_m20_q);
      b_rx_d = owag_pkg::to_s(a_m10_q);
      b_ry_d = owag_pkg::to_s(a_rh_q) - owag_pkg::to_s(a_m10_q)
             - owag_pkg::to_s(a_m20_q);
    end else if (a_kind_q == owag_pkg::KIND_VSLIDER) begin
      b_w_d  = owag_pkg::to_s(a_w40_q);
      b_h_d  = owag_pkg::to_s(a_rh_q) - (owag_pkg::to_s(a_m10_q) <<< 1);
      b_rx_d = owag_pkg::to_s(a_rw_q) - owag_pkg::to_s(a_m10_q)
             - owag_pkg::to_s(a_w40_q);
      b_ry_d = owag_pkg::to_s(a_m10_q);
    end else begin
      b_w_d  = owag_pkg::to_s(a_w20_q);
      b_h_d  = owag_pkg::to_s(a_w20_q);
      b_rx_d = owag_pkg::to_s(a_rw_q) - owag_pkg::to_s(a_m15_q)
             - owag_pkg::to_s(a_w20_q);
      b_ry_d = owag_pkg::to_s(a_m15_q);
    end
  end

  always_ff @(posedge clk_i) begin
    b_kind_q <= a_kind_q;
    b_pos_q  <= a_pos_q;
    b_w_q    <= b_w_d;
    b_h_q    <= b_h_d;
    b_rx_q   <= b_rx_d;
    b_ry_q   <= b_ry_d;
  end

  // stage C: slider products, bar width, midpoints
  logic [2:0]           c_kind_q;
  logic [6:0]           c_pos_q;
  logic                 c_empty_q, c_negx_q, c_negy_q;
  logic [19:0]          c_prodx_q, c_prody_q;
  logic signed [GW-1:0] c_w_q, c_h_q, c_rx_q, c_ry_q, c_bar_q, c_mid_q;
  logic signed [GW-1:0] c_wm1_q, c_hm1_q, c_wm2_q, c_hm2_q;
  logic signed [GW-1:0] c_wm2_d, c_hm2_d;

  assign c_wm2_d = b_w_q - GW'(2);
  assign c_hm2_d = b_h_q - GW'(2);

  always_ff @(posedge clk_i) begin
    c_kind_q  <= b_kind_q;
    c_pos_q   <= b_pos_q;
    c_empty_q <= (b_w_q <= 0) || (b_h_q <= 0) || (b_kind_q > owag_pkg::KIND_MUTE);
    c_negx_q  <= c_wm2_d < 0;
    c_negy_q  <= c_hm2_d < 0;
    c_prodx_q <= 20'(c_wm2_d[12:0]) * 20'(b_pos_q);
    c_prody_q <= 20'(c_hm2_d[12:0]) * 20'(b_pos_q);
    c_w_q     <= b_w_q;
    c_h_q     <= b_h_q;
    c_rx_q    <= b_rx_q;
    c_ry_q    <= b_ry_q;
    c_bar_q   <= owag_pkg::to_s(owag_pkg::div12(b_w_q[11:0], owag_pkg::RECIP_3));
    c_mid_q   <= b_h_q >>> 1;
    c_wm1_q   <= b_w_q - GW'(1);
    c_hm1_q   <= b_h_q - GW'(1);
    c_wm2_q   <= c_wm2_d;
    c_hm2_q   <= c_hm2_d;
  end

  // stage D: final bounds
  owag_pkg::geom_t      geom_d, geom_q;
  logic signed [GW-1:0] xp, yp, delta, q;

  always_comb begin
    if (c_negx_q) begin
      xp = (c_pos_q == owag_pkg::POS_MAX) ? {GW{1'b1}} : '0;
    end else begin
      xp = $signed(GW'(owag_pkg::div100(c_prodx_q)));
    end
    if (c_negy_q) begin
      yp = (c_pos_q == owag_pkg::POS_MAX) ? {GW{1'b1}} : '0;
    end else begin
      yp = $signed(GW'(owag_pkg::div100(c_prody_q)));
    end
    delta = (c_w_q - c_mid_q) >>> 1;
    q     = c_mid_q >>> 1;

    geom_d.kind  = c_kind_q;
    geom_d.empty = c_empty_q;
    geom_d.rx    = c_rx_q;
    geom_d.ry    = c_ry_q;
    geom_d.w     = c_w_q;
    geom_d.h     = c_h_q;
    geom_d.wm1   = c_wm1_q;
    geom_d.hm1   = c_hm1_q;
    geom_d.wm2   = c_wm2_q;
    geom_d.wm3   = c_wm2_q - GW'(1);
    geom_d.hm3   = c_hm2_q - GW'(1);
    geom_d.xlo   = xp - GW'(1);
    geom_d.xhi   = xp + GW'(1);
    geom_d.vy1   = c_h_q - yp;
    geom_d.mid   = c_mid_q;
    geom_d.bar   = c_bar_q;
    geom_d.wmb   = c_w_q - c_bar_q;
    geom_d.delta = delta;
    geom_d.wmd   = c_w_q - delta;
    geom_d.fwd   = (c_w_q - delta) >= delta;
    geom_d.y2    = (c_hm1_q >>> 1) <<< 1;
    geom_d.q     = q;
    geom_d.hm1q  = c_hm1_q - q;
  end

  always_ff @(posedge clk_i) begin
    geom_q <= geom_d;
  end

  assign geom_o = geom_q;

  a_write_unsettles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !settled_o)
    else $error("geometry reported settled right after a register write");

  a_settled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled_o && !cfg_we_i |=> settled_o)
    else $error("geometry lost settled state without a register write");

  a_settle_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settle_q <= owag_pkg::SETTLE_CYCLES)
    else $error("settle counter above its load value");

endmodule

[src/owag_pixel_pipe.sv]
// ----------------------------------------------------------------------------
// owag_pixel_pipe
// Three-stage pixel pipeline: local coordinates, shape tests, alpha.
// ----------------------------------------------------------------------------
module owag_pixel_pipe #(
  parameter int COORD_BITS = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  owag_pkg::geom_t geom_i,
  input  logic            settled_i,
  owag_pix_if.sink        pix_i,
  owag_alpha_if.source    alpha_o
);

  localparam int GW = owag_pkg::GW;
  localparam int LW = ((COORD_BITS > GW) ? COORD_BITS : GW) + 2;

  typedef logic signed [LW-1:0] lc_t;

  typedef struct packed {
    logic inr;
    logic edge_hit;
    logic hbox;
    logic vbox;
    logic vmark;
    logic pbar;
    logic sbox;
    logic diag;
    logic trow;
    lc_t  t;
    lc_t  lx;
  } s2_t;

  function automatic lc_t gx(input logic signed [GW-1:0] v);
    return LW'(v);
  endfunction

  logic rdy1, rdy2, rdy3, accept;
  logic v1_q, v2_q, v3_q;
  lc_t  lx1_q, ly1_q;
  s2_t  s2_d, s2_q;
  logic [7:0] alpha3_q, alpha3_d;
  logic inr3_q;

  assign rdy3        = !v3_q || alpha_o.ready;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign pix_i.ready = settled_i && rdy1;
  assign accept      = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= accept;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 1: region-local coordinates
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lx1_q <= $signed({{(LW-COORD_BITS){1'b0}}, pix_i.screen_x}) - gx(geom_i.rx);
      ly1_q <= $signed({{(LW-COORD_BITS){1'b0}}, pix_i.screen_y}) - gx(geom_i.ry);
    end
  end

  // stage 2: region and primitive tests
  always_comb begin
    lc_t lx, ly, yr;
    lx = lx1_q;
    ly = ly1_q;
    yr = gx(geom_i.y2) - ly;
    s2_d.inr      = !geom_i.empty && (lx >= 0) && (lx < gx(geom_i.w))
                  && (ly >= 0) && (ly < gx(geom_i.h));
    s2_d.edge_hit = (lx == 0) || (ly == 0) || (lx == gx(geom_i.wm1))
                  || (ly == gx(geom_i.hm1));
    s2_d.hbox     = (lx >= gx(geom_i.xlo)) && (lx <= gx(geom_i.xhi))
                  && (ly >= 2) && (ly <= gx(geom_i.hm3));
    s2_d.vbox     = (lx >= 2) && (lx <= gx(geom_i.wm3))
                  && (ly >= gx(geom_i.vy1)) && (ly <= gx(geom_i.hm3));
    s2_d.vmark    = ((lx == 1) || (lx == gx(geom_i.wm2))) && (ly == gx(geom_i.mid));
    s2_d.pbar     = (lx < gx(geom_i.bar)) || (lx >= gx(geom_i.wmb));
    s2_d.sbox     = (lx >= gx(geom_i.delta)) && (lx <= gx(geom_i.wmd))
                  && (ly >= gx(geom_i.q)) && (ly <= gx(geom_i.hm1q));
    s2_d.diag     = (lx >= 1) && ((lx + ly) == gx(geom_i.hm1));
    s2_d.trow     = (ly >= 0) && (ly <= gx(geom_i.y2));
    s2_d.t        = (yr < ly) ? yr : ly;
    s2_d.lx       = lx;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) s2_q <= s2_d;
  end

  // stage 3: triangles and per-kind combine
  always_comb begin
    lc_t  lx, dl, wd;
    logic ptri, stri, drawn;
    lx = s2_q.lx;
    dl = gx(geom_i.delta);
    wd = gx(geom_i.wmd);
    if (geom_i.fwd) begin
      ptri = s2_q.trow && (lx >= dl) && (lx <= dl + s2_q.t) && (lx <= wd);
    end else begin
      ptri = s2_q.trow && (lx <= dl) && (lx >= dl - s2_q.t) && (lx >= wd);
    end
    if (!geom_i.fwd || (dl == wd)) begin
      stri = s2_q.trow && (lx >= wd) && (lx <= wd + s2_q.t) && (lx <= dl);
    end else begin
      stri = s2_q.trow && (lx <= wd) && (lx >= wd - s2_q.t) && (lx >= dl);
    end
    unique case (geom_i.kind)
      owag_pkg::KIND_HSLIDER: drawn = s2_q.hbox || s2_q.edge_hit;
      owag_pkg::KIND_VSLIDER: drawn = s2_q.vbox || s2_q.vmark || s2_q.edge_hit;
      owag_pkg::KIND_PAUSE:   drawn = s2_q.pbar;
      owag_pkg::KIND_PLAY:    drawn = ptri;
      owag_pkg::KIND_SPEAKER: drawn = s2_q.sbox || stri;
      owag_pkg::KIND_MUTE:    drawn = (s2_q.sbox || stri) ^ s2_q.diag;
      default:                drawn = 1'b0;
    endcase
    alpha3_d = (s2_q.inr && drawn) ? owag_pkg::ALPHA_ON : owag_pkg::ALPHA_OFF;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      alpha3_q <= alpha3_d;
      inr3_q   <= s2_q.inr;
    end
  end

  assign alpha_o.valid     = v3_q;
  assign alpha_o.alpha     = alpha3_q;
  assign alpha_o.in_region = inr3_q;

  a_alpha_needs_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (alpha3_q != owag_pkg::ALPHA_OFF) |-> inr3_q)
    else $error("alpha drawn outside the widget region");

  a_alpha_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (alpha3_q == owag_pkg::ALPHA_ON) || (alpha3_q == owag_pkg::ALPHA_OFF))
    else $error("alpha neither fully drawn nor transparent");

  a_accept_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> settled_i)
    else $error("pixel beat taken while geometry settles");

endmodule

[src/osd_widget_alpha_generator.sv]
// ----------------------------------------------------------------------------
// osd_widget_alpha_generator
// Overlay alpha for one on-screen widget, one pixel coordinate per beat.
//
//   channel   dir  payload                   handshake
//   pix_i     in   screen_x, screen_y        valid/ready
//   alpha_o   out  alpha[7:0], in_region     valid/ready
//   cfg       in   cfg_index_i, cfg_wdata_i  cfg_we_i, no back-pressure
//
// One beat per cycle sustained while alpha_o is ready; each beat passes in turn
// through the local-coordinate, shape-test and alpha stages.
// After reset and after every register write, pix_i.ready stays low while
// the setup pipeline derives the region bounds.
// A stall on alpha_o backs up through the stages without losing beats.
// ----------------------------------------------------------------------------
module osd_widget_alpha_generator #(
  parameter int COORD_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [owag_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [owag_pkg::CFG_W-1:0]       cfg_wdata_i,
  owag_pix_if.sink                         pix_i,
  owag_alpha_if.source                     alpha_o
);

  owag_pkg::geom_t geom;
  logic            settled;

  owag_geometry u_geometry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom),
    .settled_o   (settled)
  );

  owag_pixel_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_pixel_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .geom_i    (geom),
    .settled_i (settled),
    .pix_i     (pix_i),
    .alpha_o   (alpha_o)
  );

endmodule

[tb/osd_widget_alpha_generator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// osd_widget_alpha_generator_test
// Self-checking regression for the widget alpha generator. Pixel coordinates
// go in one beat at a time under random gaps and output stalls. Each
// accepted beat gets an expected alpha from a local geometry predictor. The
// predictor is rebuilt per widget setup: slider, icon and unused kinds,
// empty regions, slider levels above full scale and the mute diagonal.
// ----------------------------------------------------------------------------
module osd_widget_alpha_generator_test;

  localparam int          COORD_BITS    = 12;
  localparam int          COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int          MAX_IDLE      = 13;
  localparam int          SETTLE_SLACK  = 4;
  localparam int          STALL_LIMIT   = 600;
  localparam int          RANDOM_BEATS  = 1700;
  localparam logic [2:0]  KIND_UNUSED6  = 3'd6;
  localparam logic [2:0]  KIND_UNUSED7  = 3'd7;

  typedef struct packed {
    logic [COORD_BITS-1:0] screen_x;
    logic [COORD_BITS-1:0] screen_y;
    logic [7:0]            alpha;
    logic                  in_region;
  } alpha_beat_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [owag_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [owag_pkg::CFG_W-1:0]     cfg_wdata_i;

  owag_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();
  owag_alpha_if                          alpha_ch ();

  osd_widget_alpha_generator #(
    .COORD_BITS (COORD_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_ch),
    .alpha_o     (alpha_ch)
  );

  logic [2:0]                 kind_reg;
  logic [owag_pkg::CFG_W-1:0] width_reg;
  logic [owag_pkg::CFG_W-1:0] height_reg;
  logic [6:0]                 pos_reg;

  alpha_beat_t expected_alpha_q[$];
  int          mismatch_count;
  int          idle_max;
  int          stalled_cycles;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void widget_region(output int rx, output int ry,
                                        output int w, output int h);
    int m;
    int rw;
    int rh;
    rw = int'(width_reg);
    rh = int'(height_reg);
    rx = 0;
    ry = 0;
    w  = 0;
    h  = 0;
    if (kind_reg == owag_pkg::KIND_HSLIDER || kind_reg == owag_pkg::KIND_VSLIDER) begin
      m = rh / 10;
      if (kind_reg == owag_pkg::KIND_HSLIDER) begin
        w  = rw - 2 * m;
        h  = rh / 20;
        rx = m;
        ry = rh - m - h;
      end else begin
        w  = rw / 40;
        h  = rh - 2 * m;
        rx = rw - m - w;
        ry = m;
      end
    end else if (kind_reg <= owag_pkg::KIND_MUTE) begin
      m  = rh / 15;
      w  = rw / 20;
      h  = w;
      rx = rw - m - w;
      ry = m;
    end
  endfunction

  function automatic bit in_rect(int lx, int ly, int x1, int y1, int x2, int y2);
    return lx >= x1 && lx <= x2 && ly >= y1 && ly <= y2;
  endfunction

  function automatic bit in_triangle(int lx, int ly, int x1, int x2, int y2);
    int t;
    if (ly < 0 || ly > y2) return 1'b0;
    t = (y2 - ly < ly) ? y2 - ly : ly;
    if (x2 >= x1) return lx >= x1 && lx <= x1 + t && lx <= x2;
    return lx <= x1 && lx >= x1 - t && lx >= x2;
  endfunction

  function automatic alpha_beat_t predict_alpha(input logic [COORD_BITS-1:0] sx,
                                                input logic [COORD_BITS-1:0] sy);
    alpha_beat_t beat;
    int          rx, ry, w, h, lx, ly, pos, mid, delta, y2;
    bit          drawn;
    beat.screen_x  = sx;
    beat.screen_y  = sy;
    beat.alpha     = owag_pkg::ALPHA_OFF;
    beat.in_region = 1'b0;
    drawn          = 1'b0;
    widget_region(rx, ry, w, h);
    if (w <= 0 || h <= 0) return beat;
    lx = int'(sx) - rx;
    ly = int'(sy) - ry;
    if (lx < 0 || lx >= w || ly < 0 || ly >= h) return beat;
    beat.in_region = 1'b1;
    pos   = (pos_reg > owag_pkg::POS_MAX) ? int'(owag_pkg::POS_MAX) : int'(pos_reg);
    mid   = h >>> 1;
    delta = (w - mid) >>> 1;
    y2    = ((h - 1) >>> 1) * 2;
    case (kind_reg)
      owag_pkg::KIND_HSLIDER: begin
        drawn = in_rect(lx, ly, (w - 2) * pos / 100 - 1, 2, (w - 2) * pos / 100 + 1, h - 3)
                || lx == 0 || ly == 0 || lx == w - 1 || ly == h - 1;
      end
      owag_pkg::KIND_VSLIDER: begin
        drawn = in_rect(lx, ly, 2, h - (h - 2) * pos / 100, w - 3, h - 3)
                || (lx == 1 && ly == h / 2) || (lx == w - 2 && ly == h / 2)
                || lx == 0 || ly == 0 || lx == w - 1 || ly == h - 1;
      end
      owag_pkg::KIND_PAUSE: begin
        drawn = lx < w / 3 || lx >= w - w / 3;
      end
      owag_pkg::KIND_PLAY: begin
        drawn = in_triangle(lx, ly, delta, w - delta, y2);
      end
      default: begin
        drawn = in_rect(lx, ly, delta, mid / 2, w - delta, h - 1 - mid / 2)
                || in_triangle(lx, ly, w - delta, delta, y2);
        if (kind_reg == owag_pkg::KIND_MUTE && lx >= 1 && lx + ly == h - 1) drawn = !drawn;
      end
    endcase
    beat.alpha = drawn ? owag_pkg::ALPHA_ON : owag_pkg::ALPHA_OFF;
    return beat;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    return COORD_BITS'(v);
  endfunction

  task automatic report_mismatch(input string what, input alpha_beat_t want,
                                 input int got, input int exp_val);
    $display("mismatch at %0t: %s pixel (%0d,%0d) got %0d expected %0d",
             $realtime, what, want.screen_x, want.screen_y, got, exp_val);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : check_result
    alpha_beat_t want;
    if (rst_ni && alpha_ch.valid && alpha_ch.ready) begin
      if (expected_alpha_q.size() == 0) begin
        want = '0;
        report_mismatch("beat with no pixel pending", want, int'(alpha_ch.alpha), 0);
      end else begin
        want = expected_alpha_q.pop_front();
        if (alpha_ch.alpha !== want.alpha)
          report_mismatch("alpha", want, int'(alpha_ch.alpha), int'(want.alpha));
        if (alpha_ch.in_region !== want.in_region)
          report_mismatch("in_region", want, int'(alpha_ch.in_region),
                          int'(want.in_region));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pix_ch.valid && pix_ch.ready) || (alpha_ch.valid && alpha_ch.ready))
      stalled_cycles = 0;
    else
      stalled_cycles++;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("osd_widget_alpha_generator regression: fail");
      $finish;
    end
  end

  initial begin : drive_ready
    int hold;
    alpha_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = $urandom_range(0, idle_max);
      if (hold > 0) begin
        alpha_ch.ready = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      alpha_ch.ready = 1'b1;
      do @(posedge clk_i); while (!alpha_ch.valid);
      @(negedge clk_i);
    end
  end

  task automatic send_pixel(input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      pix_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_ch.screen_x = x;
    pix_ch.screen_y = y;
    pix_ch.valid    = 1'b1;
    do @(posedge clk_i); while (!pix_ch.ready);
    expected_alpha_q.push_back(predict_alpha(x, y));
    @(negedge clk_i);
  endtask

  task automatic send_local(input int lx, input int ly);
    int rx, ry, w, h;
    widget_region(rx, ry, w, h);
    send_pixel(clamp_coord(rx + lx), clamp_coord(ry + ly));
  endtask

  task automatic wait_drain();
    pix_ch.valid = 1'b0;
    while (expected_alpha_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_SLACK) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [owag_pkg::CFG_IDX_W-1:0] idx,
                           input logic [owag_pkg::CFG_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic set_widget(input logic [2:0] kind, input logic [owag_pkg::CFG_W-1:0] rw,
                            input logic [owag_pkg::CFG_W-1:0] rh, input logic [6:0] pos);
    wait_drain();
    write_reg(owag_pkg::CFG_KIND, owag_pkg::CFG_W'(kind));
    write_reg(owag_pkg::CFG_WIDTH, rw);
    write_reg(owag_pkg::CFG_HEIGHT, rh);
    write_reg(owag_pkg::CFG_POS, owag_pkg::CFG_W'(pos));
    kind_reg   = kind;
    width_reg  = rw;
    height_reg = rh;
    pos_reg    = pos;
  endtask

  function automatic logic [owag_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 12'd64;
      1:       return 12'd4095;
      2:       return owag_pkg::CFG_W'($urandom_range(0, 63));
      default: return owag_pkg::CFG_W'($urandom_range(64, 4095));
    endcase
  endfunction

  task automatic test_reset_defaults();
    int rx, ry, w, h;
    widget_region(rx, ry, w, h);
    send_pixel('0, '0);
    send_pixel(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX));
    send_local(0, 0);
    send_local(1, 2);
    send_local(5, h / 2);
  endtask

  task automatic test_each_kind();
    int rx, ry, w, h;
    for (int k = 0; k <= int'(KIND_UNUSED7); k++) begin
      set_widget(3'(k), owag_pkg::RST_WIDTH, owag_pkg::RST_HEIGHT, 7'd50);
      widget_region(rx, ry, w, h);
      if (kind_reg == KIND_UNUSED6 || kind_reg == KIND_UNUSED7) begin
        send_pixel(12'd600, 12'd40);
      end else begin
        send_local(w / 2, h / 2);
        send_local(0, h - 1);
      end
    end
  endtask

  task automatic test_empty_region();
    set_widget(owag_pkg::KIND_HSLIDER, 12'd64, 12'd4095, 7'd0);
    send_pixel(12'd20, 12'd3700);
    set_widget(owag_pkg::KIND_PLAY, 12'd19, 12'd4095, 7'd0);
    send_pixel(12'd0, 12'd273);
  endtask

  task automatic test_slider_saturation();
    int rx, ry, w, h;
    set_widget(owag_pkg::KIND_HSLIDER, 12'd4095, 12'd4095, 7'd127);
    widget_region(rx, ry, w, h);
    send_local(w - 2, h / 2);
    set_widget(owag_pkg::KIND_VSLIDER, 12'd4095, 12'd64, 7'd101);
    widget_region(rx, ry, w, h);
    send_local(w / 2, 2);
  endtask

  task automatic test_mute_diagonal();
    int rx, ry, w, h;
    set_widget(owag_pkg::KIND_MUTE, owag_pkg::RST_WIDTH, owag_pkg::RST_HEIGHT, 7'd0);
    widget_region(rx, ry, w, h);
    send_local(0, h - 1);
    send_local(1, h - 2);
    send_local(w / 2, h - 1 - w / 2);
  endtask

  task automatic test_random_traffic();
    int          sent, phase, len, pick, rx, ry, w, h, lx;
    logic [2:0]  kind;
    logic [6:0]  pos;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BEATS) begin
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      pick = $urandom_range(0, 19);
      kind = (pick < 18) ? 3'(pick % 6) : 3'(int'(KIND_UNUSED6) + pick - 18);
      case ($urandom_range(0, 5))
        0:       pos = 7'd0;
        1:       pos = owag_pkg::POS_MAX;
        2:       pos = 7'($urandom_range(101, 127));
        default: pos = 7'($urandom_range(0, 100));
      endcase
      set_widget(kind, pick_size(), pick_size(), pos);
      len = $urandom_range(20, 120);
      for (int i = 0; i < len; i++) begin
        if (phase == 2 && i == len / 2) wait_drain();
        widget_region(rx, ry, w, h);
        if (w > 0 && h > 0 && $urandom_range(0, 9) < 8) begin
          if (kind_reg == owag_pkg::KIND_MUTE && $urandom_range(0, 3) == 0) begin
            lx = $urandom_range(0, w - 1);
            send_local(lx, h - 1 - lx);
          end else begin
            send_local(int'($urandom_range(0, w + 3)) - 2, int'($urandom_range(0, h + 3)) - 2);
          end
        end else begin
          send_pixel(COORD_BITS'($urandom_range(0, COORD_MAX)),
                     COORD_BITS'($urandom_range(0, COORD_MAX)));
        end
      end
      sent += len;
      phase++;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = owag_pkg::CFG_KIND;
    cfg_wdata_i     = '0;
    pix_ch.valid    = 1'b0;
    pix_ch.screen_x = '0;
    pix_ch.screen_y = '0;
    kind_reg        = owag_pkg::RST_KIND;
    width_reg       = owag_pkg::RST_WIDTH;
    height_reg      = owag_pkg::RST_HEIGHT;
    pos_reg         = owag_pkg::RST_POS;
    mismatch_count  = 0;
    stalled_cycles  = 0;
    idle_max        = MAX_IDLE;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_each_kind();
    test_empty_region();
    test_slider_saturation();
    test_mute_diagonal();
    test_random_traffic();

    wait_drain();
    if (mismatch_count == 0)
      $display("osd_widget_alpha_generator regression: pass");
    else
      $display("osd_widget_alpha_generator regression: fail");
    $finish;
  end

endmodule
